// ===== sv/tmd_pkg.sv =====
package tmd_pkg;

	localparam int SKIP_BYTES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_WIDTH = 32;
	localparam int IDX_WIDTH = 2;

	localparam logic [15:0] FIXED_A_RST = 16'd15;
	localparam logic [15:0] FIXED_B_RST = 16'd140;
	localparam logic [15:0] FIXED_C_RST = 16'd20;
	localparam logic [31:0] MAX_LEN_RST = 32'd65535;

	localparam logic [31:0] ID_CLIENT   = 32'd0;
	localparam logic [31:0] ID_VAR_A    = 32'd2;
	localparam logic [31:0] ID_VAR_B    = 32'd4;
	localparam logic [31:0] ID_FIXED_A  = 32'd5;
	localparam logic [31:0] ID_FIXED_B  = 32'd6;
	localparam logic [31:0] ID_FIXED_C  = 32'd7;
	localparam logic [31:0] ID_TAGGED_LO = 32'd10;
	localparam logic [31:0] ID_TAGGED_HI = 32'd2048;
	localparam logic [31:0] TAGGED_LEN  = 32'd8;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_FIXED_A,
		REG_FIXED_B,
		REG_FIXED_C,
		REG_MAX_LEN
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_EMPTY,
		KIND_SUBSCRIBED,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [10:0] message_id;
		logic [7:0]  payload_byte;
		logic        last_byte;
		logic [1:0]  client_kind;
	} res_t;

endpackage

// ===== sv/tmd_byte_if.sv =====
interface tmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_connection;

	modport source (output valid, output data_byte, output new_connection, input ready);
	modport sink (input valid, input data_byte, input new_connection, output ready);
endinterface

// ===== sv/tmd_result_if.sv =====
interface tmd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [10:0] message_id;
	logic [7:0]  payload_byte;
	logic        last_byte;
	logic [1:0]  client_kind;

	modport source (output valid, output kind, output message_id, output payload_byte,
		output last_byte, output client_kind, input ready);
	modport sink (input valid, input kind, input message_id, input payload_byte,
		input last_byte, input client_kind, output ready);
endinterface

// ===== sv/tmd_front.sv =====
module tmd_front #(
	parameter int SKIP_BYTES = tmd_pkg::SKIP_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tmd_pkg::IDX_WIDTH-1:0]  wr_index,
	input  logic [tmd_pkg::CFG_WIDTH-1:0]  wr_data,
	tmd_byte_if.sink                       bytes,
	input  logic                           q_full,
	output logic                           push,
	output tmd_pkg::res_t                  push_data
);

	typedef enum logic [2:0] {
		PH_ID,
		PH_SKIP,
		PH_SIZE,
		PH_DATA,
		PH_CLIENT,
		PH_CLOSED
	} phase_t;

	localparam logic [3:0] SKIP_CNT = 4'(SKIP_BYTES);

	logic [15:0] fixed_a_q, fixed_b_q, fixed_c_q;
	logic [31:0] max_len_q;

	phase_t      phase_q, ph, phase_d;
	logic [3:0]  cnt_q, cnt, cnt_d;
	logic [31:0] id_q, idw, id_d;
	logic [31:0] rem_q, rem, rem_d, rem_dec;
	logic [7:0]  cli_q, cli, cli_d;
	logic [31:0] shifted;
	logic [15:0] fixed_len;
	logic        res_v;
	tmd_pkg::res_t res;
	logic        accept;

	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;
	assign push        = accept && res_v;
	assign push_data   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_a_q <= tmd_pkg::FIXED_A_RST;
			fixed_b_q <= tmd_pkg::FIXED_B_RST;
			fixed_c_q <= tmd_pkg::FIXED_C_RST;
			max_len_q <= tmd_pkg::MAX_LEN_RST;
		end else if (wr_en) begin
			case (tmd_pkg::reg_idx_t'(wr_index))
				tmd_pkg::REG_FIXED_A: fixed_a_q <= wr_data[15:0];
				tmd_pkg::REG_FIXED_B: fixed_b_q <= wr_data[15:0];
				tmd_pkg::REG_FIXED_C: fixed_c_q <= wr_data[15:0];
				tmd_pkg::REG_MAX_LEN: max_len_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ph  = bytes.new_connection ? PH_ID : phase_q;
		cnt = bytes.new_connection ? 4'd0 : cnt_q;
		idw = bytes.new_connection ? 32'd0 : id_q;
		rem = bytes.new_connection ? 32'd0 : rem_q;
		cli = bytes.new_connection ? 8'd0 : cli_q;

		phase_d = ph;
		cnt_d   = cnt;
		id_d    = idw;
		rem_d   = rem;
		cli_d   = cli;
		res_v   = 1'b0;
		res     = '0;
		shifted = 32'(bytes.data_byte) << {cnt[1:0], 3'b000};
		rem_dec = (rem != 32'd0) ? rem - 32'd1 : 32'd0;
		fixed_len = fixed_a_q;

		case (ph)
			PH_ID: begin
				id_d  = ((cnt == 4'd0) ? 32'd0 : idw) | shifted;
				cnt_d = cnt + 4'd1;
				if (cnt_d >= 4'd4) begin
					cnt_d = 4'd0;
					if (id_d >= tmd_pkg::ID_TAGGED_LO && id_d < tmd_pkg::ID_TAGGED_HI) begin
						rem_d   = tmd_pkg::TAGGED_LEN;
						phase_d = (SKIP_BYTES == 0) ? PH_DATA : PH_SKIP;
					end else if (id_d == tmd_pkg::ID_FIXED_A || id_d == tmd_pkg::ID_FIXED_B
							|| id_d == tmd_pkg::ID_FIXED_C) begin
						if (id_d == tmd_pkg::ID_FIXED_B) fixed_len = fixed_b_q;
						else if (id_d == tmd_pkg::ID_FIXED_C) fixed_len = fixed_c_q;
						if (fixed_len == 16'd0) begin
							phase_d        = PH_ID;
							res_v          = 1'b1;
							res.kind       = tmd_pkg::KIND_EMPTY;
							res.message_id = id_d[10:0];
							res.last_byte  = 1'b1;
						end else begin
							rem_d   = 32'(fixed_len);
							phase_d = PH_DATA;
						end
					end else if (id_d == tmd_pkg::ID_CLIENT) begin
						phase_d = PH_CLIENT;
					end else if (id_d == tmd_pkg::ID_VAR_A || id_d == tmd_pkg::ID_VAR_B) begin
						phase_d = PH_SIZE;
						rem_d   = 32'd0;
					end else begin
						phase_d        = PH_CLOSED;
						res_v          = 1'b1;
						res.kind       = tmd_pkg::KIND_ERROR;
						res.message_id = id_d[10:0];
					end
				end
			end
			PH_SKIP: begin
				cnt_d = cnt + 4'd1;
				if (cnt_d >= SKIP_CNT) begin
					cnt_d   = 4'd0;
					phase_d = PH_DATA;
				end
			end
			PH_SIZE: begin
				rem_d = ((cnt == 4'd0) ? 32'd0 : rem) | shifted;
				cnt_d = cnt + 4'd1;
				if (cnt_d >= 4'd4) begin
					cnt_d = 4'd0;
					if (rem_d > max_len_q) begin
						phase_d        = PH_CLOSED;
						res_v          = 1'b1;
						res.kind       = tmd_pkg::KIND_ERROR;
						res.message_id = idw[10:0];
					end else if (rem_d == 32'd0) begin
						phase_d        = PH_ID;
						res_v          = 1'b1;
						res.kind       = tmd_pkg::KIND_EMPTY;
						res.message_id = idw[10:0];
						res.last_byte  = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				rem_d            = rem_dec;
				res_v            = 1'b1;
				res.kind         = tmd_pkg::KIND_PAYLOAD;
				res.message_id   = idw[10:0];
				res.payload_byte = bytes.data_byte;
				if (rem_dec == 32'd0) begin
					phase_d       = PH_ID;
					cnt_d         = 4'd0;
					res.last_byte = 1'b1;
				end
			end
			PH_CLIENT: begin
				if (cnt == 4'd0) begin
					cli_d = bytes.data_byte;
					cnt_d = 4'd1;
				end else begin
					cnt_d   = 4'd0;
					phase_d = PH_ID;
					if (bytes.data_byte != 8'd0) begin
						res_v = 1'b1;
						if (cli >= 8'd1 && cli <= 8'd3) begin
							res.kind        = tmd_pkg::KIND_SUBSCRIBED;
							res.client_kind = 2'(cli - 8'd1);
						end else begin
							phase_d  = PH_CLOSED;
							res.kind = tmd_pkg::KIND_ERROR;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			cnt_q   <= 4'd0;
			id_q    <= 32'd0;
			rem_q   <= 32'd0;
			cli_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			id_q    <= id_d;
			rem_q   <= rem_d;
			cli_q   <= cli_d;
		end
	end

`ifndef SYNTH
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_CLOSED && !bytes.new_connection) |-> !push)
		else $error("closed parser produced a result");
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("result pushed without an accepted item");
	a_id_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ID || phase_q == PH_SIZE) |-> cnt_q < 4'd4)
		else $error("byte counter out of range in a word phase");
`endif

endmodule

// ===== sv/tmd_queue.sv =====
module tmd_queue #(
	parameter int DEPTH = tmd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tmd_pkg::res_t push_data,
	output logic          full,
	output logic          not_empty,
	input  logic          pop,
	output tmd_pkg::res_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	tmd_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
`endif

endmodule

// ===== sv/tmd_back.sv =====
module tmd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  tmd_pkg::res_t q_data,
	output logic          pop,
	tmd_result_if.source  results
);

	logic          out_valid_q;
	tmd_pkg::res_t out_q;

	assign pop = q_not_empty && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_data;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kind         = out_q.kind;
	assign results.message_id   = out_q.message_id;
	assign results.payload_byte = out_q.payload_byte;
	assign results.last_byte    = out_q.last_byte;
	assign results.client_kind  = out_q.client_kind;

endmodule

// ===== sv/tagged_message_deframer_core.sv =====
// A result is written into the result queue at the edge that accepts its byte and is
// then loaded into the output register. Bytes are taken one per cycle while the queue
// is not full; the queue and output register decouple parsing from the output stall.
// Reset (arst_n low, asynchronous): parser returns to id collection, queue empties,
// output goes invalid, and the four length registers take their default values.
module tagged_message_deframer_core #(
	parameter int SKIP_BYTES  = tmd_pkg::SKIP_BYTES_DEF,
	parameter int QUEUE_DEPTH = tmd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tmd_pkg::IDX_WIDTH-1:0] wr_index,
	input  logic [tmd_pkg::CFG_WIDTH-1:0] wr_data,
	tmd_byte_if.sink                      bytes,
	tmd_result_if.source                  results
);

	logic          q_full;
	logic          q_not_empty;
	logic          push;
	logic          pop;
	tmd_pkg::res_t push_data;
	tmd_pkg::res_t pop_data;

	tmd_front #(
		.SKIP_BYTES(SKIP_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.bytes     (bytes),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tmd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	tmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.results     (results)
	);

endmodule
